FILE: sv/tcw_pkg.sv
// shared constants and types of the text console character writer
package tcw_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;

    localparam int W_ACTION   = 1;
    localparam int W_BYTE     = 8;
    localparam int W_RROW     = 6;
    localparam int W_RCOL     = 7;
    localparam int W_CELL     = 8;
    localparam int W_CCOL     = 7;
    localparam int W_CROW     = 6;
    localparam int W_COLS_REG = 8;
    localparam int W_ROWS_REG = 7;
    localparam int W_CFG_DATA = 8;
    localparam int W_CFG_IDX  = 1;

    localparam int COLS_RESET = 80;
    localparam int ROWS_RESET = 24;

    localparam logic [W_BYTE-1:0] BYTE_CR = 8'h0D;
    localparam logic [W_BYTE-1:0] BYTE_LF = 8'h0A;

    localparam logic [W_ACTION-1:0] ACT_PUT  = 1'b0;
    localparam logic [W_ACTION-1:0] ACT_READ = 1'b1;

    localparam logic [W_CFG_IDX-1:0] CFG_COLS = 1'b0;
    localparam logic [W_CFG_IDX-1:0] CFG_ROWS = 1'b1;

    typedef struct packed {
        logic store;
        logic scroll;
    } t_put_ctl;

endpackage

FILE: sv/tcw_if.sv
// input and output channel interfaces of the text console character writer
interface tcw_in_if;
    logic                             valid;
    logic                             ready;
    logic [tcw_pkg::W_ACTION-1:0]     action;
    logic [tcw_pkg::W_BYTE-1:0]       char_byte;
    logic [tcw_pkg::W_RROW-1:0]       read_row;
    logic [tcw_pkg::W_RCOL-1:0]       read_col;

    modport source (output valid, action, char_byte, read_row, read_col, input ready);
    modport sink   (input valid, action, char_byte, read_row, read_col, output ready);
endinterface

interface tcw_out_if;
    logic                             valid;
    logic                             ready;
    logic [tcw_pkg::W_CELL-1:0]       cell_value;
    logic [tcw_pkg::W_CCOL-1:0]       cursor_col_out;
    logic [tcw_pkg::W_CROW-1:0]       cursor_row_out;
    logic                             scrolled;

    modport source (output valid, cell_value, cursor_col_out, cursor_row_out, scrolled,
                    input ready);
    modport sink   (input valid, cell_value, cursor_col_out, cursor_row_out, scrolled,
                    output ready);
endinterface

FILE: sv/tcw_ram.sv
// generic simple dual port ram with registered read
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tcw_cursor.sv
// cursor, wrap flag and scroll decision for one put beat
module tcw_cursor #(
    parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
    input  logic [$clog2(MAX_COLS)-1:0]   i_col,
    input  logic [$clog2(MAX_ROWS)-1:0]   i_row,
    input  logic                          i_wrapped,
    input  logic [$clog2(MAX_COLS+1)-1:0] i_cols,
    input  logic [$clog2(MAX_ROWS+1)-1:0] i_rows,
    input  logic [tcw_pkg::W_BYTE-1:0]    i_byte,
    output logic [$clog2(MAX_COLS)-1:0]   o_col,
    output logic [$clog2(MAX_ROWS)-1:0]   o_row,
    output logic                          o_wrapped,
    output logic [$clog2(MAX_COLS)-1:0]   o_st_col,
    output logic [$clog2(MAX_ROWS)-1:0]   o_st_row,
    output tcw_pkg::t_put_ctl             o_ctl
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CNW = $clog2(MAX_COLS + 1);
    localparam int RNW = $clog2(MAX_ROWS + 1);

    logic [CW-1:0]  col_c;
    logic [RW-1:0]  row_c;
    logic [CNW-1:0] col_inc;
    logic [RNW-1:0] row_nxt;
    logic           row_inc;

    always_comb begin
        col_c     = (CNW'(i_col) >= i_cols) ? CW'(i_cols - CNW'(1)) : i_col;
        row_c     = (RNW'(i_row) >= i_rows) ? RW'(i_rows - RNW'(1)) : i_row;
        col_inc   = CNW'(col_c) + CNW'(1);
        row_inc   = 1'b0;
        o_col     = col_c;
        o_wrapped = i_wrapped;
        o_ctl     = '0;
        if (i_byte == tcw_pkg::BYTE_CR) begin
            o_col = '0;
        end else if (i_byte != tcw_pkg::BYTE_LF) begin
            o_ctl.store = 1'b1;
            if (col_inc >= i_cols) begin
                o_col     = '0;
                row_inc   = 1'b1;
                o_wrapped = 1'b1;
            end else begin
                o_col     = CW'(col_inc);
                o_wrapped = 1'b0;
            end
        end else if (!i_wrapped) begin
            row_inc = 1'b1;
        end else begin
            o_wrapped = 1'b0;
        end
        row_nxt = RNW'(row_c) + RNW'(row_inc);
        if (row_nxt >= i_rows) begin
            o_ctl.scroll = 1'b1;
            o_row        = RW'(i_rows - RNW'(1));
        end else begin
            o_row = RW'(row_nxt);
        end
    end

    assign o_st_col = col_c;
    assign o_st_row = row_c;

endmodule

FILE: sv/text_console_char_writer_core.sv
// top level of the text console character writer
// Usage: i_in carries one beat per item: action 0 puts char_byte from the host
// stream at the cursor (carriage return, line feed and auto-wrap handled), action 1
// reads the visible cell at read_row, read_col. o_out returns exactly one beat per
// item with the cell (zero for a put), the cursor after the item and a scroll flag.
// Column and row counts are written through i_cfg_we, i_cfg_idx, i_cfg_data; the user
// must do so only while idle, as the block itself does not enforce it.
// Timing: a put passes through S_EXEC and S_SEND before its result is registered at the
// output; a read in range also passes through S_RDATA, for the registered read of the
// screen ram. A scroll adds one write sweep of MAX_COLS cells over the new bottom row,
// since the ram writes one cell per cycle. When the row count was lowered to or below
// the stored top-row offset, an item first stays in S_EXEC, subtracting the row count
// from the offset until it is smaller; a put keeps the reduced offset, a read does not.
// Reset: the ram is swept to zero, one cell per cycle, over all MAX_COLS*MAX_ROWS cells
// (8192 by default), and i_in.ready stays low for that time; config writes still land.
// Stall: the result sits in an output register; the next item is accepted and
// executed meanwhile, and its result waits until the output register is taken.
module text_console_char_writer_core #(
    parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tcw_in_if.sink                           i_in,
    tcw_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [tcw_pkg::W_CFG_IDX-1:0]    i_cfg_idx,
    input  logic [tcw_pkg::W_CFG_DATA-1:0]   i_cfg_data
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CNW   = $clog2(MAX_COLS + 1);
    localparam int RNW   = $clog2(MAX_ROWS + 1);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CEW   = (CNW > tcw_pkg::W_COLS_REG) ? CNW : tcw_pkg::W_COLS_REG;
    localparam int REW   = (RNW > tcw_pkg::W_ROWS_REG) ? RNW : tcw_pkg::W_ROWS_REG;
    localparam int RCW   = (RNW > tcw_pkg::W_RROW) ? RNW : tcw_pkg::W_RROW;
    localparam int CCW   = (CNW > tcw_pkg::W_RCOL) ? CNW : tcw_pkg::W_RCOL;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_RDATA,
        S_CLEAR,
        S_SEND
    } t_state;

    function automatic logic [CNW-1:0] clamp_cols(input logic [tcw_pkg::W_COLS_REG-1:0] v);
        logic [CEW-1:0] ext;
        ext = CEW'(v);
        if (v == '0) begin
            return CNW'(1);
        end else if (ext > CEW'(MAX_COLS)) begin
            return CNW'(MAX_COLS);
        end
        return CNW'(v);
    endfunction

    function automatic logic [RNW-1:0] clamp_rows(input logic [tcw_pkg::W_ROWS_REG-1:0] v);
        logic [REW-1:0] ext;
        ext = REW'(v);
        if (v == '0) begin
            return RNW'(1);
        end else if (ext > REW'(MAX_ROWS)) begin
            return RNW'(MAX_ROWS);
        end
        return RNW'(v);
    endfunction

    // visible row to physical cell address through the rotating top offset
    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] top,
                                                input logic [RW-1:0] vis,
                                                input logic [CW-1:0] col,
                                                input logic [RNW-1:0] rows);
        logic [RW:0]   sum;
        logic [RW-1:0] phys;
        sum = {1'b0, top} + {1'b0, vis};
        if (sum >= (RW+1)'(rows)) begin
            phys = RW'(sum - (RW+1)'(rows));
        end else begin
            phys = RW'(sum);
        end
        return AW'(phys) * AW'(MAX_COLS) + AW'(col);
    endfunction

    t_state                         r_state;
    logic [AW-1:0]                  r_cnt;
    logic [AW-1:0]                  r_clr_base;
    logic [CNW-1:0]                 r_cols_eff;
    logic [RNW-1:0]                 r_rows_eff;
    logic [CW-1:0]                  r_ccol;
    logic [RW-1:0]                  r_crow;
    logic                           r_wrapped;
    logic [RW-1:0]                  r_top;
    logic [RW-1:0]                  r_topw;
    logic [tcw_pkg::W_ACTION-1:0]   r_act;
    logic [tcw_pkg::W_BYTE-1:0]     r_byte;
    logic [tcw_pkg::W_RROW-1:0]     r_rrow;
    logic [tcw_pkg::W_RCOL-1:0]     r_rcol;
    logic [tcw_pkg::W_CELL-1:0]     r_res_cell;
    logic                           r_res_scr;
    logic                           r_out_valid;
    logic [tcw_pkg::W_CELL-1:0]     r_out_cell;
    logic [tcw_pkg::W_CCOL-1:0]     r_out_col;
    logic [tcw_pkg::W_CROW-1:0]     r_out_row;
    logic                           r_out_scr;

    logic [CW-1:0]                  n_col;
    logic [RW-1:0]                  n_row;
    logic                           n_wrapped;
    logic [CW-1:0]                  st_col;
    logic [RW-1:0]                  st_row;
    tcw_pkg::t_put_ctl              put_ctl;

    logic                           top_ok;
    logic                           rd_in_rng;
    logic                           out_free;
    logic                           in_ready;
    logic                           in_acc;
    logic [RNW-1:0]                 top_p1;
    logic [RW-1:0]                  top_inc;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [tcw_pkg::W_CELL-1:0]     ram_wdata;
    logic                           ram_re;
    logic [AW-1:0]                  ram_raddr;
    logic [tcw_pkg::W_CELL-1:0]     ram_rdata;

    tcw_cursor #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cursor (
        .i_col     (r_ccol),
        .i_row     (r_crow),
        .i_wrapped (r_wrapped),
        .i_cols    (r_cols_eff),
        .i_rows    (r_rows_eff),
        .i_byte    (r_byte),
        .o_col     (n_col),
        .o_row     (n_row),
        .o_wrapped (n_wrapped),
        .o_st_col  (st_col),
        .o_st_row  (st_row),
        .o_ctl     (put_ctl)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::W_CELL),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        top_ok    = RNW'(r_topw) < r_rows_eff;
        rd_in_rng = (RCW'(r_rrow) < RCW'(r_rows_eff)) && (CCW'(r_rcol) < CCW'(r_cols_eff));
        out_free  = !r_out_valid || o_out.ready;
        in_ready  = (r_state == S_IDLE) || ((r_state == S_SEND) && out_free);
        in_acc    = in_ready && i_in.valid;
        top_p1    = RNW'(r_topw) + RNW'(1);
        top_inc   = (top_p1 >= r_rows_eff) ? '0 : RW'(top_p1);
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = cell_addr(r_topw, RW'(r_rrow), CW'(r_rcol), r_rows_eff);
        case (r_state)
            S_INIT: begin
                ram_we = 1'b1;
            end
            S_EXEC: begin
                if (top_ok && (r_act == tcw_pkg::ACT_PUT) && put_ctl.store) begin
                    ram_we    = 1'b1;
                    ram_waddr = cell_addr(r_topw, st_row, st_col, r_rows_eff);
                    ram_wdata = r_byte;
                end
                if (top_ok && (r_act == tcw_pkg::ACT_READ) && rd_in_rng) begin
                    ram_re = 1'b1;
                end
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_base + r_cnt;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_cols_eff  <= clamp_cols(tcw_pkg::W_COLS_REG'(tcw_pkg::COLS_RESET));
            r_rows_eff  <= clamp_rows(tcw_pkg::W_ROWS_REG'(tcw_pkg::ROWS_RESET));
            r_ccol      <= '0;
            r_crow      <= '0;
            r_wrapped   <= 1'b0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tcw_pkg::CFG_COLS: r_cols_eff <= clamp_cols(i_cfg_data);
                    tcw_pkg::CFG_ROWS:
                        r_rows_eff <= clamp_rows(i_cfg_data[tcw_pkg::W_ROWS_REG-1:0]);
                endcase
            end
            if ((r_state == S_SEND) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_act  <= i_in.action;
                r_byte <= i_in.char_byte;
                r_rrow <= i_in.read_row;
                r_rcol <= i_in.read_col;
                r_topw <= r_top;
            end
            unique case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (!top_ok) begin
                        r_topw <= r_topw - RW'(r_rows_eff);
                    end else if (r_act == tcw_pkg::ACT_READ) begin
                        r_res_cell <= '0;
                        r_res_scr  <= 1'b0;
                        r_state    <= rd_in_rng ? S_RDATA : S_SEND;
                    end else begin
                        r_ccol     <= n_col;
                        r_crow     <= n_row;
                        r_wrapped  <= n_wrapped;
                        r_res_cell <= '0;
                        r_res_scr  <= put_ctl.scroll;
                        if (put_ctl.scroll) begin
                            r_top      <= top_inc;
                            r_clr_base <= AW'(r_topw) * AW'(MAX_COLS);
                            r_cnt      <= '0;
                            r_state    <= S_CLEAR;
                        end else begin
                            r_top   <= r_topw;
                            r_state <= S_SEND;
                        end
                    end
                end
                S_RDATA: begin
                    r_res_cell <= ram_rdata;
                    r_state    <= S_SEND;
                end
                S_CLEAR: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == AW'(MAX_COLS - 1)) begin
                        r_state <= S_SEND;
                    end
                end
                S_SEND: begin
                    if (out_free) begin
                        r_out_cell  <= r_res_cell;
                        r_out_col   <= tcw_pkg::W_CCOL'(r_ccol);
                        r_out_row   <= tcw_pkg::W_CROW'(r_crow);
                        r_out_scr   <= r_res_scr;
                        r_state     <= in_acc ? S_EXEC : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    assign i_in.ready           = in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.cell_value     = r_out_cell;
    assign o_out.cursor_col_out = r_out_col;
    assign o_out.cursor_row_out = r_out_row;
    assign o_out.scrolled       = r_out_scr;

    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !in_ready)
        else $error("item accepted during ram clear");

    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && (r_act == tcw_pkg::ACT_READ)) |-> !ram_we)
        else $error("read item wrote the screen ram");

    a_scroll_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && top_ok && (r_act == tcw_pkg::ACT_PUT) && put_ctl.scroll)
        |=> (r_state == S_CLEAR) && (r_cnt == '0))
        else $error("scroll without row clear");

    a_put_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && top_ok && (r_act == tcw_pkg::ACT_PUT))
        |=> (RNW'(r_crow) < r_rows_eff) && (CNW'(r_ccol) < r_cols_eff)
            && (RNW'(r_top) < r_rows_eff))
        else $error("cursor or top offset off screen after put");

    a_result_waits_for_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEND) && !out_free) |=> (r_state == S_SEND) && $stable(r_res_cell))
        else $error("result lost while output stalled");

endmodule

FILE: tb/tb_text_console_char_writer_core.sv
// self-checking testbench of the text console character writer: predicts every beat of o_out
module tb_text_console_char_writer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GLYPH_DEPTH = tcw_pkg::MAX_COLS_DEF * tcw_pkg::MAX_ROWS_DEF;
    localparam int QUIET_LIMIT = 40000;

    typedef struct packed {
        logic [tcw_pkg::W_ACTION-1:0] action;
        logic [tcw_pkg::W_BYTE-1:0]   char_byte;
        logic [tcw_pkg::W_RROW-1:0]   read_row;
        logic [tcw_pkg::W_RCOL-1:0]   read_col;
    } t_console_item;

    typedef struct packed {
        logic [tcw_pkg::W_CELL-1:0] cell_value;
        logic [tcw_pkg::W_CCOL-1:0] cursor_col_out;
        logic [tcw_pkg::W_CROW-1:0] cursor_row_out;
        logic                       scrolled;
    } t_console_report;

    class t_console_scoreboard;
        logic [tcw_pkg::W_CELL-1:0]     glyphs [GLYPH_DEPTH];
        int unsigned                    top_offset;
        int unsigned                    cur_col;
        int unsigned                    cur_row;
        bit                             wrap_pending;
        logic [tcw_pkg::W_COLS_REG-1:0] cols_reg;
        logic [tcw_pkg::W_ROWS_REG-1:0] rows_reg;
        t_console_report                expected_reports [$];
        int unsigned                    fails;

        function new();
            foreach (glyphs[k]) glyphs[k] = '0;
            top_offset   = 0;
            cur_col      = 0;
            cur_row      = 0;
            wrap_pending = 1'b0;
            cols_reg     = tcw_pkg::W_COLS_REG'(tcw_pkg::COLS_RESET);
            rows_reg     = tcw_pkg::W_ROWS_REG'(tcw_pkg::ROWS_RESET);
            fails        = 0;
        endfunction

        function void set_register(logic [tcw_pkg::W_CFG_IDX-1:0] idx,
                                   logic [tcw_pkg::W_CFG_DATA-1:0] data);
            if (idx == tcw_pkg::CFG_COLS) begin
                cols_reg = data;
            end else begin
                rows_reg = data[tcw_pkg::W_ROWS_REG-1:0];
            end
        endfunction

        function int unsigned active_cols();
            if (cols_reg == 0) return 1;
            if (cols_reg > tcw_pkg::MAX_COLS_DEF) return tcw_pkg::MAX_COLS_DEF;
            return 32'(cols_reg);
        endfunction

        function int unsigned active_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > tcw_pkg::MAX_ROWS_DEF) return tcw_pkg::MAX_ROWS_DEF;
            return 32'(rows_reg);
        endfunction

        function int unsigned glyph_index(int unsigned vis_row, int unsigned col,
                                          int unsigned rows);
            int unsigned phys;
            phys = ((top_offset % rows) + vis_row) % rows;
            return (phys * tcw_pkg::MAX_COLS_DEF + col) % GLYPH_DEPTH;
        endfunction

        function void predict_item(t_console_item it);
            int unsigned     cols;
            int unsigned     rows;
            int unsigned     base;
            t_console_report rep;
            cols = active_cols();
            rows = active_rows();
            rep  = '0;
            if (it.action == tcw_pkg::ACT_READ) begin
                if (it.read_row < rows && it.read_col < cols)
                    rep.cell_value = glyphs[glyph_index(it.read_row, it.read_col, rows)];
            end else begin
                if (cur_col >= cols) cur_col = cols - 1;
                if (cur_row >= rows) cur_row = rows - 1;
                top_offset = top_offset % rows;
                if (it.char_byte == tcw_pkg::BYTE_CR) begin
                    cur_col = 0;
                end else begin
                    if (it.char_byte != tcw_pkg::BYTE_LF) begin
                        glyphs[glyph_index(cur_row, cur_col, rows)] = it.char_byte;
                        cur_col++;
                        if (cur_col >= cols) begin
                            cur_col      = 0;
                            cur_row++;
                            wrap_pending = 1'b1;
                        end else begin
                            wrap_pending = 1'b0;
                        end
                    end else if (!wrap_pending) begin
                        cur_row++;
                    end else begin
                        // line feed right after a wrap is swallowed
                        wrap_pending = 1'b0;
                    end
                    if (cur_row >= rows) begin
                        cur_row    = rows - 1;
                        top_offset = (top_offset + 1) % rows;
                        base       = glyph_index(rows - 1, 0, rows);
                        for (int k = 0; k < tcw_pkg::MAX_COLS_DEF; k++) glyphs[base + k] = '0;
                        rep.scrolled = 1'b1;
                    end
                end
            end
            rep.cursor_col_out = cur_col[tcw_pkg::W_CCOL-1:0];
            rep.cursor_row_out = cur_row[tcw_pkg::W_CROW-1:0];
            expected_reports.push_back(rep);
        endfunction

        function void check_field(string what, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                fails++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, what, want, got);
            end
        endfunction

        function void check_report(t_console_report got);
            t_console_report want;
            if (expected_reports.size() == 0) begin
                fails++;
                $display("%0t: result beat with nothing expected, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_reports.pop_front();
            check_field("cell_value", want.cell_value, got.cell_value);
            check_field("cursor_col_out", 8'(want.cursor_col_out), 8'(got.cursor_col_out));
            check_field("cursor_row_out", 8'(want.cursor_row_out), 8'(got.cursor_row_out));
            check_field("scrolled", 8'(want.scrolled), 8'(got.scrolled));
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [tcw_pkg::W_CFG_IDX-1:0]  i_cfg_idx;
    logic [tcw_pkg::W_CFG_DATA-1:0] i_cfg_data;
    bit                             steady;
    int unsigned                    quiet_cycles = 0;

    tcw_in_if  in_ch ();
    tcw_out_if out_ch ();

    t_console_scoreboard sb = new();

    text_console_char_writer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_report({out_ch.cell_value, out_ch.cursor_col_out,
                             out_ch.cursor_row_out, out_ch.scrolled});
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_console_item make_item(logic [tcw_pkg::W_ACTION-1:0] act,
                                                logic [tcw_pkg::W_BYTE-1:0] ch,
                                                logic [tcw_pkg::W_RROW-1:0] row,
                                                logic [tcw_pkg::W_RCOL-1:0] col);
        t_console_item it;
        it.action    = act;
        it.char_byte = ch;
        it.read_row  = row;
        it.read_col  = col;
        return it;
    endfunction

    // mostly text with line breaks, reads mostly inside the screen
    function automatic t_console_item random_item();
        t_console_item it;
        int unsigned   pick;
        int unsigned   cols;
        int unsigned   rows;
        cols = sb.active_cols();
        rows = sb.active_rows();
        pick = $urandom_range(0, 99);
        it.char_byte = 8'($urandom_range(8'h20, 8'h7E));
        it.read_row  = tcw_pkg::W_RROW'($urandom_range(0, 63));
        it.read_col  = tcw_pkg::W_RCOL'($urandom_range(0, 127));
        it.action    = tcw_pkg::ACT_PUT;
        if (pick < 25) begin
            it.action    = tcw_pkg::ACT_READ;
            it.char_byte = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 80) begin
                it.read_row = tcw_pkg::W_RROW'($urandom_range(0, rows - 1));
                it.read_col = tcw_pkg::W_RCOL'($urandom_range(0, cols - 1));
            end
        end else if (pick < 35) begin
            it.char_byte = tcw_pkg::BYTE_CR;
        end else if (pick < 47) begin
            it.char_byte = tcw_pkg::BYTE_LF;
        end else if (pick < 55) begin
            it.char_byte = 8'($urandom_range(0, 255));
        end
        return it;
    endfunction

    task automatic write_reg(logic [tcw_pkg::W_CFG_IDX-1:0] idx,
                             logic [tcw_pkg::W_CFG_DATA-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_register(idx, data);
    endtask

    task automatic offer_item(t_console_item it);
        while (!steady && $urandom_range(0, 99) < 10) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.action    = it.action;
        in_ch.char_byte = it.char_byte;
        in_ch.read_row  = it.read_row;
        in_ch.read_col  = it.read_col;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.predict_item(it);
        @(negedge i_clk);
    endtask

    // hold off until every result is back, then let a scroll sweep finish
    task automatic settle();
        in_ch.valid = 1'b0;
        while (sb.expected_reports.size() != 0) @(negedge i_clk);
        repeat (tcw_pkg::MAX_COLS_DEF + 8) @(negedge i_clk);
    endtask

    initial begin
        t_console_item script [$];
        int unsigned   phase_cols [7];
        int unsigned   phase_rows [7];
        int unsigned   phase_len  [7];

        phase_cols      = '{255, 5, 0, 3, 40, 80, 1};
        phase_rows      = '{127, 3, 0, 64, 7, 24, 127};
        phase_len       = '{200, 200, 150, 250, 200, 200, 200};
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = tcw_pkg::CFG_COLS;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.action    = tcw_pkg::ACT_PUT;
        in_ch.char_byte = '0;
        in_ch.read_row  = '0;
        in_ch.read_col  = '0;
        steady          = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // tiny screen: wrap, swallowed line feed, scroll, reads in and out of range
        write_reg(tcw_pkg::CFG_COLS, 8'd2);
        write_reg(tcw_pkg::CFG_ROWS, 8'd2);
        script.push_back(make_item(tcw_pkg::ACT_READ, 8'h00, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_PUT, 8'h41, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_PUT, 8'h00, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_PUT, tcw_pkg::BYTE_LF, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_PUT, 8'hFF, 6'd63, 7'd127));
        script.push_back(make_item(tcw_pkg::ACT_PUT, 8'h7E, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_PUT, tcw_pkg::BYTE_CR, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_PUT, tcw_pkg::BYTE_LF, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_PUT, tcw_pkg::BYTE_LF, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_READ, 8'hFF, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_READ, 8'h00, 6'd0, 7'd1));
        script.push_back(make_item(tcw_pkg::ACT_READ, 8'h00, 6'd1, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_READ, 8'h00, 6'd63, 7'd127));
        script.push_back(make_item(tcw_pkg::ACT_READ, 8'h00, 6'd0, 7'd2));
        script.push_back(make_item(tcw_pkg::ACT_PUT, tcw_pkg::BYTE_CR, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_PUT, 8'h80, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_PUT, tcw_pkg::BYTE_LF, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_PUT, tcw_pkg::BYTE_LF, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_READ, 8'h00, 6'd0, 7'd1));
        foreach (script[k]) offer_item(script[k]);
        settle();

        // single row, single column: every line advance scrolls
        write_reg(tcw_pkg::CFG_COLS, 8'd1);
        write_reg(tcw_pkg::CFG_ROWS, 8'd1);
        script.delete();
        script.push_back(make_item(tcw_pkg::ACT_PUT, 8'h78, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_PUT, tcw_pkg::BYTE_LF, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_PUT, tcw_pkg::BYTE_LF, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_READ, 8'h00, 6'd0, 7'd0));
        script.push_back(make_item(tcw_pkg::ACT_PUT, tcw_pkg::BYTE_CR, 6'd0, 7'd0));
        foreach (script[k]) offer_item(script[k]);
        settle();

        for (int p = 0; p < 7; p++) begin
            write_reg(tcw_pkg::CFG_COLS, tcw_pkg::W_CFG_DATA'(phase_cols[p]));
            write_reg(tcw_pkg::CFG_ROWS, tcw_pkg::W_CFG_DATA'(phase_rows[p]));
            steady = (p == 3);
            for (int n = 0; n < phase_len[p]; n++) begin
                offer_item(random_item());
                if ($urandom_range(0, 199) == 0) settle();
            end
            settle();
        end
        steady = 1'b0;

        if (sb.fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
